/* src/ilst_pkg.sv */
// Shared types, constants and helpers for the indexed insert/erase list.
`default_nettype none
package ilst_pkg;

   localparam int DEPTH      = 16;
   localparam int ELEM_WIDTH = 32;

   localparam int CMD_W  = 3;
   localparam int POS_W  = 5;
   localparam int WORD_W = 32;
   localparam int STAT_W = 2;
   localparam int CNT_W  = 5;
   localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH   = 3'd0,
      CMD_POP    = 3'd1,
      CMD_INSERT = 3'd2,
      CMD_ERASE  = 3'd3,
      CMD_GET    = 3'd4,
      CMD_SET    = 3'd5,
      CMD_CLEAR  = 3'd6
   } cmd_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK    = 2'd0,
      ST_INDEX = 2'd1,
      ST_EMPTY = 2'd2,
      ST_FULL  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_LOAD,
      CELL_FROM_LOWER,
      CELL_FROM_UPPER
   } cell_op_type;

   typedef logic [ELEM_WIDTH-1:0] elem_type;

   typedef struct packed {
      status_type          status;
      logic [CNT_W-1:0]    count_next;
      logic                rd_en;
      logic [IDX_W-1:0]    rd_idx;
   } ctl_result_type;

   typedef struct packed {
      status_type          status;
      logic [WORD_W-1:0]   rdata;
      logic [CNT_W-1:0]    count;
      logic                is_empty;
   } rsp_type;

   function automatic elem_type to_elem(input logic [WORD_W-1:0] w);
      logic [63:0] ext;
      ext = {32'd0, w};
      return ext[ELEM_WIDTH-1:0];
   endfunction

   function automatic logic [WORD_W-1:0] to_word(input elem_type e);
      logic [127:0] ext;
      ext = {{(128-ELEM_WIDTH){1'b0}}, e};
      return ext[WORD_W-1:0];
   endfunction

endpackage
`default_nettype wire

/* src/indexed_insert_erase_list_core.sv */
// Top level of the indexed insert/erase list: cell chain, count and output stage.
//
// Usage:
//   Requests enter on req_* (cmd, position, wdata) and are taken at a rising
//   edge with req_valid high and req_stall low. Every request yields exactly
//   one response on rsp_* (status, rdata, count_out, is_empty), taken at an
//   edge with rsp_valid high and rsp_stall low.
//   Response: the response to a taken request is registered in the output
//   register, or in the skid register while the output is held. Throughput:
//   one request per cycle while req_stall is low. All cells of the chain move
//   in the same cycle, so an insert or erase anywhere is as quick as any other.
//   Stall: a response held by rsp_stall stays put; one further response is
//   parked in a skid register, and req_stall rises only while that register
//   is occupied.
//   Reset (synchronous, active high): the count goes to zero and both output
//   registers empty. The stored words are not cleared; entries at or above
//   the count are never read.
//   Status codes: ok, index out of range, empty (pop on empty list), full
//   (push or insert with no room). rdata is zero unless a pop or get succeeds.
`default_nettype none
module indexed_insert_erase_list_core (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           req_valid,
   output logic                          req_stall,
   input  wire  [ilst_pkg::CMD_W-1:0]    req_cmd,
   input  wire  [ilst_pkg::POS_W-1:0]    req_position,
   input  wire  [ilst_pkg::WORD_W-1:0]   req_wdata,
   output logic                          rsp_valid,
   input  wire                           rsp_stall,
   output logic [ilst_pkg::STAT_W-1:0]   rsp_status,
   output logic [ilst_pkg::WORD_W-1:0]   rsp_rdata,
   output logic [ilst_pkg::CNT_W-1:0]    rsp_count_out,
   output logic                          rsp_is_empty
);

   logic                        fire;
   logic [ilst_pkg::CNT_W-1:0]  count_ff;
   logic [ilst_pkg::CNT_W-1:0]  count_in;
   ilst_pkg::cell_op_type       cell_ops [ilst_pkg::DEPTH];
   ilst_pkg::ctl_result_type    ctl;
   ilst_pkg::elem_type          cell_data [ilst_pkg::DEPTH];
   ilst_pkg::elem_type          wword;
   ilst_pkg::rsp_type           new_rsp;

   logic                        out_valid_ff, out_valid_in;
   ilst_pkg::rsp_type           out_ff, out_in;
   logic                        skid_valid_ff, skid_valid_in;
   ilst_pkg::rsp_type           skid_ff, skid_in;
   logic                        advance;

   assign req_stall = skid_valid_ff;
   assign fire      = req_valid && !req_stall;
   assign wword     = ilst_pkg::to_elem(req_wdata);

   ilst_ctrl u_ctrl (
      .cmd      (req_cmd),
      .position (req_position),
      .count    (count_ff),
      .fire     (fire),
      .cell_ops (cell_ops),
      .result   (ctl)
   );

   for (genvar g = 0; g < ilst_pkg::DEPTH; g++) begin : g_cell
      ilst_pkg::elem_type lower_w;
      ilst_pkg::elem_type upper_w;
      if (g == 0) begin : g_first
         assign lower_w = '0;
      end else begin : g_mid_lo
         assign lower_w = cell_data[g-1];
      end
      if (g == ilst_pkg::DEPTH - 1) begin : g_last
         assign upper_w = '0;
      end else begin : g_mid_hi
         assign upper_w = cell_data[g+1];
      end
      ilst_cell u_cell (
         .clock      (clock),
         .op         (cell_ops[g]),
         .wdata      (wword),
         .lower_data (lower_w),
         .upper_data (upper_w),
         .data       (cell_data[g])
      );
   end

   // read select reads the cells before this cycle's update
   always_comb begin
      new_rsp.status   = ctl.status;
      new_rsp.rdata    = ctl.rd_en ? ilst_pkg::to_word(cell_data[ctl.rd_idx]) : '0;
      new_rsp.count    = ctl.count_next;
      new_rsp.is_empty = (ctl.count_next == '0);
   end

   assign count_in = fire ? ctl.count_next : count_ff;
   assign advance  = !out_valid_ff || !rsp_stall;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (advance) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in  = fire;
            out_in        = new_rsp;
         end
      end else if (fire) begin
         // park the response while the output is held
         skid_valid_in = 1'b1;
         skid_in       = new_rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_status    = out_ff.status;
   assign rsp_rdata     = out_ff.rdata;
   assign rsp_count_out = out_ff.count;
   assign rsp_is_empty  = out_ff.is_empty;

endmodule
`default_nettype wire

/* src/ilst_cell.sv */
// One storage cell of the list: holds a word, loads or takes a neighbor's word.
`default_nettype none
module ilst_cell (
   input  wire                          clock,
   input  ilst_pkg::cell_op_type        op,
   input  wire  [ilst_pkg::ELEM_WIDTH-1:0] wdata,
   input  wire  [ilst_pkg::ELEM_WIDTH-1:0] lower_data,
   input  wire  [ilst_pkg::ELEM_WIDTH-1:0] upper_data,
   output logic [ilst_pkg::ELEM_WIDTH-1:0] data
);

   logic [ilst_pkg::ELEM_WIDTH-1:0] data_ff;
   logic [ilst_pkg::ELEM_WIDTH-1:0] data_in;

   always_comb begin
      case (op)
         ilst_pkg::CELL_LOAD:       data_in = wdata;
         ilst_pkg::CELL_FROM_LOWER: data_in = lower_data;
         ilst_pkg::CELL_FROM_UPPER: data_in = upper_data;
         default:                   data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule
`default_nettype wire

/* src/ilst_ctrl.sv */
// Command decode: status, next count, read select and per-cell operations.
`default_nettype none
module ilst_ctrl (
   input  wire  [ilst_pkg::CMD_W-1:0]  cmd,
   input  wire  [ilst_pkg::POS_W-1:0]  position,
   input  wire  [ilst_pkg::CNT_W-1:0]  count,
   input  wire                         fire,
   output ilst_pkg::cell_op_type       cell_ops [ilst_pkg::DEPTH],
   output ilst_pkg::ctl_result_type    result
);

   logic full;
   logic empty;
   logic pos_le_count;
   logic pos_lt_count;
   logic [ilst_pkg::CNT_W-1:0] pos_cnt;
   logic [ilst_pkg::CNT_W-1:0] count_m1;
   ilst_pkg::cmd_type cmd_e;

   assign cmd_e        = ilst_pkg::cmd_type'(cmd);
   assign full         = (count >= ilst_pkg::CNT_W'(ilst_pkg::DEPTH));
   assign empty        = (count == '0);
   assign pos_cnt      = ilst_pkg::CNT_W'(position);
   assign pos_le_count = (pos_cnt <= count);
   assign pos_lt_count = (pos_cnt < count);
   assign count_m1     = count - ilst_pkg::CNT_W'(1);

   always_comb begin
      result.status     = ilst_pkg::ST_OK;
      result.count_next = count;
      result.rd_en      = 1'b0;
      result.rd_idx     = position[ilst_pkg::IDX_W-1:0];
      for (int i = 0; i < ilst_pkg::DEPTH; i++) begin
         cell_ops[i] = ilst_pkg::CELL_HOLD;
      end

      case (cmd_e)
         ilst_pkg::CMD_PUSH: begin
            if (full) begin
               result.status = ilst_pkg::ST_FULL;
            end else begin
               result.count_next = count + ilst_pkg::CNT_W'(1);
               for (int i = 0; i < ilst_pkg::DEPTH; i++) begin
                  if (ilst_pkg::CNT_W'(i) == count) cell_ops[i] = ilst_pkg::CELL_LOAD;
               end
            end
         end
         ilst_pkg::CMD_POP: begin
            if (empty) begin
               result.status = ilst_pkg::ST_EMPTY;
            end else begin
               result.count_next = count_m1;
               result.rd_en      = 1'b1;
               result.rd_idx     = count_m1[ilst_pkg::IDX_W-1:0];
            end
         end
         ilst_pkg::CMD_INSERT: begin
            if (!pos_le_count) begin
               result.status = ilst_pkg::ST_INDEX;
            end else if (full) begin
               result.status = ilst_pkg::ST_FULL;
            end else begin
               result.count_next = count + ilst_pkg::CNT_W'(1);
               // shift the tail up one cell, drop the new word at position
               for (int i = 0; i < ilst_pkg::DEPTH; i++) begin
                  if (ilst_pkg::CNT_W'(i) == pos_cnt) begin
                     cell_ops[i] = ilst_pkg::CELL_LOAD;
                  end else if (ilst_pkg::CNT_W'(i) > pos_cnt) begin
                     cell_ops[i] = ilst_pkg::CELL_FROM_LOWER;
                  end
               end
            end
         end
         ilst_pkg::CMD_ERASE: begin
            if (!pos_lt_count) begin
               result.status = ilst_pkg::ST_INDEX;
            end else begin
               result.count_next = count_m1;
               for (int i = 0; i < ilst_pkg::DEPTH; i++) begin
                  if (ilst_pkg::CNT_W'(i) >= pos_cnt) cell_ops[i] = ilst_pkg::CELL_FROM_UPPER;
               end
            end
         end
         ilst_pkg::CMD_GET: begin
            if (!pos_lt_count) begin
               result.status = ilst_pkg::ST_INDEX;
            end else begin
               result.rd_en = 1'b1;
            end
         end
         ilst_pkg::CMD_SET: begin
            if (!pos_lt_count) begin
               result.status = ilst_pkg::ST_INDEX;
            end else begin
               for (int i = 0; i < ilst_pkg::DEPTH; i++) begin
                  if (ilst_pkg::CNT_W'(i) == pos_cnt) cell_ops[i] = ilst_pkg::CELL_LOAD;
               end
            end
         end
         ilst_pkg::CMD_CLEAR: begin
            result.count_next = '0;
         end
         default: begin
         end
      endcase

      // no request this cycle: every cell holds
      if (!fire) begin
         for (int i = 0; i < ilst_pkg::DEPTH; i++) begin
            cell_ops[i] = ilst_pkg::CELL_HOLD;
         end
      end
   end

endmodule
`default_nettype wire

/* src/ilst_checker.sv */
// Port-level checks on the list core and the bind that attaches them.
`default_nettype none
module ilst_checker (
   input wire                          clock,
   input wire                          reset,
   input wire                          rsp_valid,
   input wire                          rsp_stall,
   input wire [ilst_pkg::STAT_W-1:0]   rsp_status,
   input wire [ilst_pkg::WORD_W-1:0]   rsp_rdata,
   input wire [ilst_pkg::CNT_W-1:0]    rsp_count_out,
   input wire                          rsp_is_empty
);

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_is_empty == (rsp_count_out == '0)))
      else $error("is_empty disagrees with count_out");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_count_out <= ilst_pkg::CNT_W'(ilst_pkg::DEPTH)))
      else $error("count_out above capacity");

   a_fail_no_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != ilst_pkg::ST_OK)) |-> (rsp_rdata == '0))
      else $error("failed request returned data");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ilst_pkg::ST_FULL))
         |-> (rsp_count_out == ilst_pkg::CNT_W'(ilst_pkg::DEPTH)))
      else $error("full status with room left");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_rdata) && $stable(rsp_status)))
      else $error("stalled response changed");

endmodule

bind indexed_insert_erase_list_core ilst_checker u_ilst_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_status    (rsp_status),
   .rsp_rdata     (rsp_rdata),
   .rsp_count_out (rsp_count_out),
   .rsp_is_empty  (rsp_is_empty)
);
`default_nettype wire

/* bench/ilst_list_checker.sv */
// Request/response monitor for the indexed list: predicts each response and compares it.
`timescale 1ns / 100ps
`default_nettype none
module ilst_list_checker
   import ilst_pkg::*;
(
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   input  wire                 req_stall,
   input  wire  [CMD_W-1:0]    req_cmd,
   input  wire  [POS_W-1:0]    req_position,
   input  wire  [WORD_W-1:0]   req_wdata,
   input  wire                 rsp_valid,
   input  wire                 rsp_stall,
   input  wire  [STAT_W-1:0]   rsp_status,
   input  wire  [WORD_W-1:0]   rsp_rdata,
   input  wire  [CNT_W-1:0]    rsp_count_out,
   input  wire                 rsp_is_empty,
   output int                  mismatches,
   output int                  outstanding,
   output int                  compared
);

   elem_type list_words [DEPTH];
   int       fill;
   rsp_type  expected_rsp [$];

   initial begin
      mismatches  = 0;
      outstanding = 0;
      compared    = 0;
      fill        = 0;
      for (int i = 0; i < DEPTH; i++) begin
         list_words[i] = '0;
      end
   end

   // Apply one request to the shadow list and return the response it must produce.
   function automatic rsp_type apply_command(input logic [CMD_W-1:0] op,
                                             input logic [POS_W-1:0] position,
                                             input logic [WORD_W-1:0] word);
      rsp_type r;
      int      pos;
      elem_type value;
      pos      = int'(position);
      value    = elem_type'(word);
      r.status = ST_OK;
      r.rdata  = '0;
      case (op)
         CMD_PUSH: begin
            if (fill >= DEPTH) begin
               r.status = ST_FULL;
            end else begin
               list_words[fill] = value;
               fill++;
            end
         end
         CMD_POP: begin
            if (fill == 0) begin
               r.status = ST_EMPTY;
            end else begin
               fill--;
               r.rdata = list_words[fill];
            end
         end
         CMD_INSERT: begin
            // index check wins over the full check
            if (pos > fill) begin
               r.status = ST_INDEX;
            end else if (fill >= DEPTH) begin
               r.status = ST_FULL;
            end else begin
               for (int i = fill; i > pos; i--) begin
                  list_words[i] = list_words[i-1];
               end
               list_words[pos] = value;
               fill++;
            end
         end
         CMD_ERASE: begin
            if (pos >= fill) begin
               r.status = ST_INDEX;
            end else begin
               for (int i = pos; i + 1 < fill; i++) begin
                  list_words[i] = list_words[i+1];
               end
               fill--;
            end
         end
         CMD_GET: begin
            if (pos >= fill) begin
               r.status = ST_INDEX;
            end else begin
               r.rdata = list_words[pos];
            end
         end
         CMD_SET: begin
            if (pos >= fill) begin
               r.status = ST_INDEX;
            end else begin
               list_words[pos] = value;
            end
         end
         CMD_CLEAR: begin
            fill = 0;
         end
         default: begin
         end
      endcase
      r.count    = fill[CNT_W-1:0];
      r.is_empty = (fill == 0);
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         fill = 0;
         expected_rsp.delete();
      end else begin
         // compare first: a response never belongs to the request taken at the same edge
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp.size() == 0) begin
               $error("response with no request outstanding: status %0d rdata %h count %0d",
                      rsp_status, rsp_rdata, rsp_count_out);
               mismatches++;
            end else begin
               want = expected_rsp.pop_front();
               compared++;
               if (rsp_status !== want.status) begin
                  $error("rsp_status: expected %0d, got %0d", want.status, rsp_status);
                  mismatches++;
               end
               if (rsp_rdata !== want.rdata) begin
                  $error("rsp_rdata: expected %h, got %h", want.rdata, rsp_rdata);
                  mismatches++;
               end
               if (rsp_count_out !== want.count) begin
                  $error("rsp_count_out: expected %0d, got %0d", want.count, rsp_count_out);
                  mismatches++;
               end
               if (rsp_is_empty !== want.is_empty) begin
                  $error("rsp_is_empty: expected %0d, got %0d", want.is_empty, rsp_is_empty);
                  mismatches++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            expected_rsp.push_back(apply_command(req_cmd, req_position, req_wdata));
         end
      end
      outstanding = expected_rsp.size();
   end

endmodule
`default_nettype wire

/* bench/tb_indexed_insert_erase_list_core.sv */
// Top-level bench for the indexed list: clock, reset, request stimulus and verdict.
`timescale 1ns / 100ps
`default_nettype none
module tb_indexed_insert_erase_list_core;
   import ilst_pkg::*;

   localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;
   localparam int REQUEST_GOAL = 1900;

   logic                clock         = 1'b0;
   logic                reset         = 1'b1;
   logic                req_valid     = 1'b0;
   logic                req_stall;
   logic [CMD_W-1:0]    req_cmd       = '0;
   logic [POS_W-1:0]    req_position  = '0;
   logic [WORD_W-1:0]   req_wdata     = '0;
   logic                rsp_valid;
   logic                rsp_stall     = 1'b0;
   logic [STAT_W-1:0]   rsp_status;
   logic [WORD_W-1:0]   rsp_rdata;
   logic [CNT_W-1:0]    rsp_count_out;
   logic                rsp_is_empty;

   int mismatches;
   int outstanding;
   int compared;

   // 0: no idling, 1: light, 2: heavy
   int req_idle_mode = 0;
   int rsp_idle_mode = 0;

   int list_count   = 0;
   int target_count = 0;
   int sent         = 0;
   int directed     = 0;
   int full_hits    = 0;
   int empty_hits   = 0;

   indexed_insert_erase_list_core uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_cmd       (req_cmd),
      .req_position  (req_position),
      .req_wdata     (req_wdata),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_status    (rsp_status),
      .rsp_rdata     (rsp_rdata),
      .rsp_count_out (rsp_count_out),
      .rsp_is_empty  (rsp_is_empty)
   );

   ilst_list_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_cmd       (req_cmd),
      .req_position  (req_position),
      .req_wdata     (req_wdata),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_status    (rsp_status),
      .rsp_rdata     (rsp_rdata),
      .rsp_count_out (rsp_count_out),
      .rsp_is_empty  (rsp_is_empty),
      .mismatches    (mismatches),
      .outstanding   (outstanding),
      .compared      (compared)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("FAILURE");
      $finish;
   end

   // Mostly short idle stretches, now and then a long one.
   function automatic int idle_length();
      if ($urandom_range(0, 99) < 85) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(4, 24);
   endfunction

   function automatic bit start_idle(input int mode);
      if (mode == 0) begin
         return 1'b0;
      end
      return $urandom_range(0, 99) < ((mode == 2) ? 35 : 12);
   endfunction

   // Track the list size so the stimulus can aim positions at live entries.
   function automatic int count_after(input logic [CMD_W-1:0] op, input int pos, input int cnt);
      case (op)
         CMD_PUSH:   return (cnt < DEPTH) ? cnt + 1 : cnt;
         CMD_POP:    return (cnt > 0) ? cnt - 1 : cnt;
         CMD_INSERT: return (pos <= cnt && cnt < DEPTH) ? cnt + 1 : cnt;
         CMD_ERASE:  return (pos < cnt) ? cnt - 1 : cnt;
         CMD_CLEAR:  return 0;
         default:    return cnt;
      endcase
   endfunction

   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            stall_left--;
         end else if (start_idle(rsp_idle_mode)) begin
            stall_left = idle_length();
         end
         rsp_stall <= (stall_left > 0);
      end
   end

   // Present one request and hold it until the block takes it.
   task automatic send_request(input logic [CMD_W-1:0] op, input int pos,
                               input logic [WORD_W-1:0] word);
      int gap;
      int next_count;
      gap = start_idle(req_idle_mode) ? idle_length() : 0;
      repeat (gap) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_cmd      <= op;
      req_position <= pos[POS_W-1:0];
      req_wdata    <= word;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      next_count = count_after(op, pos, list_count);
      if (next_count == DEPTH && list_count != DEPTH) begin
         full_hits++;
      end
      if (next_count == 0 && list_count != 0) begin
         empty_hits++;
      end
      list_count = next_count;
      sent++;
   endtask

   function automatic logic [WORD_W-1:0] random_word();
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) begin
         return '0;
      end
      if (r == 1) begin
         return '1;
      end
      return $urandom;
   endfunction

   // Fill to capacity, then probe every way of hitting a full list.
   task automatic fill_and_probe();
      while (list_count < DEPTH) begin
         send_request(CMD_PUSH, 0, random_word());
      end
      send_request(CMD_PUSH, 0, random_word());
      send_request(CMD_INSERT, $urandom_range(0, DEPTH), random_word());
      send_request(CMD_INSERT, $urandom_range(DEPTH + 1, 31), random_word());
      send_request(CMD_GET, DEPTH - 1, '0);
      send_request(CMD_ERASE, $urandom_range(0, DEPTH - 1), '0);
      send_request(CMD_INSERT, $urandom_range(0, list_count), random_word());
   endtask

   task automatic random_request();
      int r;
      int p;
      int pos;
      logic [CMD_W-1:0] op;
      bit grow;
      r    = $urandom_range(0, 99);
      grow = (list_count < target_count);
      if (r < 2) begin
         op = CMD_UNUSED;
      end else if (r < 4) begin
         op = CMD_CLEAR;
      end else if (r < 20) begin
         op = CMD_GET;
      end else if (r < 32) begin
         op = CMD_SET;
      end else if (r < 70) begin
         if (grow) begin
            op = (r < 51) ? CMD_PUSH : CMD_INSERT;
         end else begin
            op = (r < 51) ? CMD_POP : CMD_ERASE;
         end
      end else begin
         op = CMD_W'($urandom_range(0, 6));
      end
      p = $urandom_range(0, 99);
      if (p < 80) begin
         if (op == CMD_INSERT) begin
            pos = $urandom_range(0, list_count);
         end else begin
            pos = (list_count > 0) ? $urandom_range(0, list_count - 1) : 0;
         end
      end else if (p < 90) begin
         pos = list_count + $urandom_range(0, 1);
      end else begin
         pos = $urandom_range(0, 31);
      end
      send_request(op, pos, random_word());
   endtask

   initial begin
      int phase;
      phase = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed opening: empty list, boundaries, shifts, unused code, clear
      send_request(CMD_POP, 0, '0);
      send_request(CMD_GET, 0, '0);
      send_request(CMD_ERASE, 0, '0);
      send_request(CMD_SET, 0, 32'hDEAD_BEEF);
      send_request(CMD_INSERT, 1, 32'h1111_1111);
      send_request(CMD_INSERT, 0, 32'hFFFF_FFFF);
      send_request(CMD_PUSH, 0, 32'h0000_0000);
      send_request(CMD_PUSH, 31, 32'hA5A5_A5A5);
      send_request(CMD_INSERT, 3, 32'h1234_5678);
      send_request(CMD_INSERT, 31, 32'h5555_5555);
      send_request(CMD_INSERT, 1, 32'h8000_0001);
      send_request(CMD_GET, 4, '0);
      send_request(CMD_GET, 5, '0);
      send_request(CMD_GET, 31, '0);
      send_request(CMD_SET, 1, 32'h7FFF_FFFE);
      send_request(CMD_ERASE, 0, '0);
      send_request(CMD_ERASE, 3, '0);
      send_request(CMD_ERASE, 16, '0);
      send_request(CMD_UNUSED, 0, 32'hFFFF_FFFF);
      send_request(CMD_POP, 0, '0);
      send_request(CMD_CLEAR, 0, '0);
      send_request(CMD_POP, 0, '0);
      send_request(CMD_PUSH, 0, 32'h5A5A_5A5A);
      send_request(CMD_CLEAR, 9, '0);
      send_request(CMD_GET, 0, '0);
      directed = sent;

      while (sent < REQUEST_GOAL) begin
         req_idle_mode = phase % 3;
         rsp_idle_mode = (phase / 3) % 3;
         if (phase % 2 == 0) begin
            fill_and_probe();
         end
         repeat (150) begin
            if ($urandom_range(0, 39) == 0) begin
               // swing the aim between empty, full and in between
               case ($urandom_range(0, 3))
                  0:       target_count = 0;
                  1:       target_count = DEPTH;
                  default: target_count = $urandom_range(0, DEPTH);
               endcase
            end
            random_request();
         end
         phase++;
      end
      req_valid <= 1'b0;

      // let the monitor log the last request before reading its backlog
      @(negedge clock);
      while (outstanding != 0) begin
         @(negedge clock);
      end
      repeat (8) @(negedge clock);

      $display("Sent %0d requests (%0d directed), compared %0d responses.",
               sent, directed, compared);
      $display("List reached capacity %0d times and drained to empty %0d times.",
               full_hits, empty_hits);
      if (mismatches == 0 && outstanding == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
`default_nettype wire
